// ----- src/modular_inverse_defines.svh -----
// Assertion helpers shared by the modular inverse RTL.
// Both expect i_clk and i_rst_n in the enclosing module.
`ifndef MODULAR_INVERSE_DEFINES_SVH
`define MODULAR_INVERSE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define MI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/mi_pkg.sv -----
`timescale 1ns / 1ps

package mi_pkg;

    // Status of the shared divide / multiply-accumulate unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ----- src/mi_divunit.sv -----
`timescale 1ns / 1ps
`include "modular_inverse_defines.svh"

// Restoring divider, one quotient bit per cycle, MSB first. Each quotient bit
// also feeds a shift-add accumulator, so the product quotient * mcand is ready
// together with the remainder.
module mi_divunit import mi_pkg::*; #(
    parameter int WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [WIDTH:0]        i_dividend,
    input  logic [WIDTH-1:0]      i_divisor,
    input  logic [WIDTH+1:0]      i_mcand,
    output t_div_stat             o_stat,
    output logic [WIDTH-1:0]      o_rem,
    output logic [WIDTH+1:0]      o_prod
);

    localparam int CW    = WIDTH + 2;
    localparam int CNT_W = $clog2(WIDTH + 2);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [WIDTH:0]   r_num, n_num;
    logic [WIDTH-1:0] r_div, n_div;
    logic [WIDTH-1:0] r_rem, n_rem;
    logic [CW-1:0]    r_mc, n_mc;
    logic [CW-1:0]    r_acc, n_acc;

    logic [WIDTH:0]   w_shift;
    logic [WIDTH:0]   w_diff;
    logic             w_ge;

    assign w_shift = {r_rem, r_num[WIDTH]};
    assign w_diff  = w_shift - {1'b0, r_div};
    assign w_ge    = w_shift >= {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_div  = r_div;
        n_rem  = r_rem;
        n_mc   = r_mc;
        n_acc  = r_acc;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(WIDTH + 1);
            n_num  = i_dividend;
            n_div  = i_divisor;
            n_rem  = '0;
            n_mc   = i_mcand;
            n_acc  = '0;
        end else if (r_busy) begin
            n_num = {r_num[WIDTH-1:0], 1'b0};
            // partial remainder stays below the divisor, so W bits hold it
            n_rem = w_ge ? w_diff[WIDTH-1:0] : w_shift[WIDTH-1:0];
            n_acc = {r_acc[CW-2:0], 1'b0} + (w_ge ? r_mc : '0);
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_div <= n_div;
        r_rem <= n_rem;
        r_mc  <= n_mc;
        r_acc <= n_acc;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rem       = r_rem;
    assign o_prod      = r_acc;

    `MI_ASSERT_NOW(a_start_idle, i_start, !r_busy && !r_done, "start while unit occupied")
    `MI_ASSERT_NEXT(a_last_done, r_busy && r_cnt == CNT_W'(1), r_done && !r_busy,
        "last iteration did not raise done")
    `MI_ASSERT_NEXT(a_keep_busy, r_busy && r_cnt != CNT_W'(1) && !i_start, r_busy && !r_done,
        "unit left busy early")

endmodule

// ----- src/modular_inverse.sv -----
`timescale 1ns / 1ps
`include "modular_inverse_defines.svh"

// Modular inverse by the extended Euclidean algorithm. One item is in work
// at a time; o_in_stall stays high from acceptance until the result has
// moved into the output register. Every Euclid step passes the check state
// and then runs one division on a shared bit-serial divider (quotient times
// coefficient is accumulated alongside). A final pass on the same divider
// reduces the coefficient modulo the modulus; a zero modulus skips the
// reduction. The output register lets the next item be taken while a result
// still waits on o_out_valid.
module modular_inverse import mi_pkg::*; #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [WIDTH-1:0] i_value,
    input  logic [WIDTH-1:0] i_modulus,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [WIDTH-1:0] o_inverse,
    output logic [WIDTH-1:0] o_common_divisor,
    output logic             o_no_inverse,
    output logic             o_modulus_zero
);

    localparam int CW = WIDTH + 2;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_RED  = 3'd3;
    localparam logic [2:0] S_WB   = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [WIDTH-1:0] r_rp, n_rp;      // previous remainder
    logic [WIDTH-1:0] r_rc, n_rc;      // current remainder
    logic [CW-1:0]    r_cp, n_cp;      // coefficient of value, previous
    logic [CW-1:0]    r_cc, n_cc;      // coefficient of value, current
    logic [WIDTH-1:0] r_mod, n_mod;

    logic             r_ovalid, n_ovalid;
    logic [WIDTH-1:0] r_inv, n_inv;
    logic [WIDTH-1:0] r_gcd, n_gcd;
    logic             r_noinv, n_noinv;
    logic             r_mzero, n_mzero;

    logic             w_start;
    logic [WIDTH:0]   w_dividend;
    logic [WIDTH-1:0] w_divisor;
    logic [CW-1:0]    w_mcand;
    t_div_stat        w_stat;
    logic [WIDTH-1:0] w_rem;
    logic [CW-1:0]    w_prod;

    logic             w_neg;
    logic [CW-1:0]    w_abs;
    logic [WIDTH-1:0] w_red;
    logic             w_out_free;

    assign w_neg = r_cp[CW-1];
    assign w_abs = w_neg ? (CW'(0) - r_cp) : r_cp;

    // one Euclid division while the remainder is nonzero, else the reduction unless the modulus is zero
    always_comb begin
        w_start    = (r_state == S_CHK) && ((r_rc != '0) || (r_mod != '0));
        w_dividend = {1'b0, r_rp};
        w_divisor  = r_rc;
        w_mcand    = r_cc;
        if (r_rc == '0) begin
            w_dividend = w_abs[WIDTH:0];
            w_divisor  = r_mod;
            w_mcand    = '0;
        end
    end

    mi_divunit #(
        .WIDTH      (WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .i_mcand    (w_mcand),
        .o_stat     (w_stat),
        .o_rem      (w_rem),
        .o_prod     (w_prod)
    );

    // negative coefficient folds back as modulus minus remainder
    always_comb begin
        if (r_mod == '0) begin
            w_red = '0;
        end else if (w_neg && (w_rem != '0)) begin
            w_red = r_mod - w_rem;
        end else begin
            w_red = w_rem;
        end
    end

    assign w_out_free = !r_ovalid || !i_out_stall;

    always_comb begin
        n_state  = r_state;
        n_rp     = r_rp;
        n_rc     = r_rc;
        n_cp     = r_cp;
        n_cc     = r_cc;
        n_mod    = r_mod;
        n_ovalid = r_ovalid && i_out_stall;
        n_inv    = r_inv;
        n_gcd    = r_gcd;
        n_noinv  = r_noinv;
        n_mzero  = r_mzero;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_rp    = i_modulus;
                    n_rc    = i_value;
                    n_cp    = '0;
                    n_cc    = CW'(1);
                    n_mod   = i_modulus;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_rc != '0) begin
                    n_state = S_DIV;
                end else if (r_mod != '0) begin
                    n_state = S_RED;
                end else begin
                    n_state = S_WB;
                end
            end
            S_DIV: begin
                if (w_stat.done) begin
                    n_rp    = r_rc;
                    n_rc    = w_rem;
                    n_cp    = r_cc;
                    n_cc    = r_cp - w_prod;
                    n_state = S_CHK;
                end
            end
            S_RED: begin
                if (w_stat.done) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_inv    = w_red;
                    n_gcd    = r_rp;
                    n_noinv  = r_rp != WIDTH'(1);
                    n_mzero  = r_mod == '0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_rp    <= n_rp;
        r_rc    <= n_rc;
        r_cp    <= n_cp;
        r_cc    <= n_cc;
        r_mod   <= n_mod;
        r_inv   <= n_inv;
        r_gcd   <= n_gcd;
        r_noinv <= n_noinv;
        r_mzero <= n_mzero;
    end

    assign o_in_stall       = r_state != S_IDLE;
    assign o_out_valid      = r_ovalid;
    assign o_inverse        = r_inv;
    assign o_common_divisor = r_gcd;
    assign o_no_inverse     = r_noinv;
    assign o_modulus_zero   = r_mzero;

    `MI_ASSERT_NOW(a_mzero_inv, o_out_valid && o_modulus_zero, o_inverse == '0,
        "zero modulus with nonzero inverse")
    `MI_ASSERT_NOW(a_div_active, r_state == S_DIV || r_state == S_RED,
        w_stat.busy || w_stat.done, "waiting on idle divider")
    `MI_ASSERT_NEXT(a_chk_div, r_state == S_CHK && r_rc != '0,
        r_state == S_DIV && w_stat.busy, "Euclid step did not start divider")

endmodule

// ----- tb/modular_inverse_monitor.sv -----
`timescale 1ns / 1ps

module modular_inverse_monitor #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  logic [WIDTH-1:0] i_value,
    input  logic [WIDTH-1:0] i_modulus,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  logic [WIDTH-1:0] i_inverse,
    input  logic [WIDTH-1:0] i_common_divisor,
    input  logic             i_no_inverse,
    input  logic             i_modulus_zero,
    output int               o_outstanding,
    output int               o_mismatch_count
);

    localparam int STEP_CAP = 2 * WIDTH + 8;

    typedef struct packed {
        logic [WIDTH-1:0] inverse;
        logic [WIDTH-1:0] common_divisor;
        logic             no_inverse;
        logic             modulus_zero;
    } t_inv_result;

    t_inv_result expected_inverses[$];
    int          mismatches = 0;

    // Coefficients are carried modulo 2^64; their true values stay within +-2^63.
    function automatic t_inv_result compute_inverse(logic [WIDTH-1:0] val,
                                                    logic [WIDTH-1:0] modv);
        logic [63:0] r_prev, r_cur, r_next;
        logic [63:0] c_prev, c_cur, c_next;
        logic [63:0] quot, m64, rem, reduced;
        int          steps;
        t_inv_result res;
        m64    = 64'(modv);
        r_prev = 64'(modv);
        r_cur  = 64'(val);
        c_prev = 64'd0;
        c_cur  = 64'd1;
        steps  = 0;
        while (r_cur != 64'd0 && steps < STEP_CAP) begin
            quot   = r_prev / r_cur;
            r_next = r_prev - quot * r_cur;
            c_next = c_prev - quot * c_cur;
            r_prev = r_cur;
            r_cur  = r_next;
            c_prev = c_cur;
            c_cur  = c_next;
            steps++;
        end
        if (m64 == 64'd0) begin
            reduced = 64'd0;
        end else if (c_prev[63]) begin
            rem     = (64'd0 - c_prev) % m64;
            reduced = (rem != 64'd0) ? m64 - rem : 64'd0;
        end else begin
            reduced = c_prev % m64;
        end
        res.inverse        = reduced[WIDTH-1:0];
        res.common_divisor = r_prev[WIDTH-1:0];
        res.no_inverse     = (r_prev != 64'd1);
        res.modulus_zero   = (m64 == 64'd0);
        return res;
    endfunction

    task automatic check_field(string name, logic [WIDTH-1:0] want, logic [WIDTH-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_inv_result want;
        if (i_rst_n) begin
            // retire the older result before queueing the new transfer
            if (i_out_valid && !i_out_stall) begin
                if (expected_inverses.size() == 0) begin
                    $error("result transfer with no item outstanding");
                    mismatches++;
                end else begin
                    want = expected_inverses.pop_front();
                    check_field("inverse", want.inverse, i_inverse);
                    check_field("common_divisor", want.common_divisor, i_common_divisor);
                    check_field("no_inverse", WIDTH'(want.no_inverse), WIDTH'(i_no_inverse));
                    check_field("modulus_zero", WIDTH'(want.modulus_zero),
                                WIDTH'(i_modulus_zero));
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_inverses = {expected_inverses, compute_inverse(i_value, i_modulus)};
        end
        o_outstanding    <= expected_inverses.size();
        o_mismatch_count <= mismatches;
    end

endmodule

// ----- tb/modular_inverse_test.sv -----
`timescale 1ns / 1ps

module modular_inverse_test;

    localparam int WIDTH         = 32;
    localparam int RANDOM_ITEMS  = 352;
    localparam int CALM_ITEMS    = 30;
    localparam int SQUEEZE_AT    = 40;
    localparam int HOLD_CYCLES   = 5000;
    localparam int IDLE_LIMIT    = 20000;
    localparam int TAIL_CYCLES   = 60;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic [WIDTH-1:0] i_value     = '0;
    logic [WIDTH-1:0] i_modulus   = '0;
    logic             i_out_stall = 1'b0;
    logic             o_in_stall;
    logic             o_out_valid;
    logic [WIDTH-1:0] o_inverse;
    logic [WIDTH-1:0] o_common_divisor;
    logic             o_no_inverse;
    logic             o_modulus_zero;

    int outstanding;
    int mismatch_count;
    int items_sent   = 0;
    bit calm         = 1'b0;

    logic [WIDTH-1:0] fib_seq [0:45];

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    modular_inverse #(.WIDTH(WIDTH)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_value         (i_value),
        .i_modulus       (i_modulus),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_inverse       (o_inverse),
        .o_common_divisor(o_common_divisor),
        .o_no_inverse    (o_no_inverse),
        .o_modulus_zero  (o_modulus_zero)
    );

    modular_inverse_monitor #(.WIDTH(WIDTH)) monitor (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_value         (i_value),
        .i_modulus       (i_modulus),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_inverse       (o_inverse),
        .i_common_divisor(o_common_divisor),
        .i_no_inverse    (o_no_inverse),
        .i_modulus_zero  (o_modulus_zero),
        .o_outstanding   (outstanding),
        .o_mismatch_count(mismatch_count)
    );

    // Offer one item and hold it until the transfer happens.
    task automatic send_item(logic [WIDTH-1:0] val, logic [WIDTH-1:0] modv);
        int bursts;
        if (!calm && $urandom_range(0, 2) == 0) begin
            // now and then a long run of bursts so the gap ends at a random phase
            bursts = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 100) : 1;
            i_in_valid <= 1'b0;
            repeat (bursts) repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= val;
        i_modulus  <= modv;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    // Result side: random stall bursts, one long hold-off, none at the end.
    initial begin
        bit held;
        held = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && items_sent >= SQUEEZE_AT) begin
                held = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 1) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
    end

    // Watchdog on cycles without any transfer.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        logic [WIDTH-1:0] val, modv, factor;
        int               idx;
        fib_seq[0] = 1;
        fib_seq[1] = 2;
        for (int k = 2; k < 46; k++)
            fib_seq[k] = fib_seq[k-1] + fib_seq[k-2];

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero modulus, zero value, modulus one, gcd not one, extremes
        send_item(0, 0);
        send_item(1, 0);
        send_item(32'hFFFF_FFFF, 0);
        send_item(0, 7);
        send_item(0, 32'hFFFF_FFFF);
        send_item(3, 11);
        send_item(10, 17);
        send_item(6, 9);
        send_item(12, 1);
        send_item(1, 1);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_item(32'd1836311903, 32'd2971215073);
        send_item(32'd2971215073, 32'd1836311903);
        send_item(7, 32'hFFFF_FFFB);
        send_item(32'h8000_0000, 32'hFFFF_FFFF);
        send_item(32'h5555_5555, 32'hAAAA_AAAA);
        send_item(32'd123456789, 1);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
            val  = $urandom;
            modv = $urandom;
            case ($urandom_range(0, 9))
                4: begin
                    val  = $urandom_range(0, 255);
                    modv = $urandom_range(0, 255);
                end
                5: begin
                    factor = $urandom_range(2, 2000);
                    val    = factor * $urandom_range(0, 32'hFFFF_FFFF / factor);
                    modv   = factor * $urandom_range(0, 32'hFFFF_FFFF / factor);
                end
                6: begin
                    case ($urandom_range(0, 2))
                        0: val  = 0;
                        1: modv = 0;
                        default: modv = 1;
                    endcase
                end
                7: begin
                    modv = $urandom_range(0, 32'hFFFF_FF00);
                    val  = modv + $urandom_range(0, 3);
                end
                8: begin
                    // consecutive Fibonacci numbers give the longest Euclid runs
                    idx  = $urandom_range(20, 44);
                    val  = fib_seq[idx];
                    modv = fib_seq[idx + 1];
                    if ($urandom_range(0, 1) == 0) begin
                        val  = fib_seq[idx + 1];
                        modv = fib_seq[idx];
                    end
                end
                9: begin
                    val  = $urandom | 32'h8000_0000;
                    modv = $urandom | 32'h8000_0000;
                end
                default: ;
            endcase
            send_item(val, modv);
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
